// ----- hw/rtl/wis_pkg.sv -----
// package for the weighted index select unit: field widths, register and request codes,
// controller/datapath command and status structs
// no dependencies
`default_nettype none

package wis_pkg;

	// parameter defaults
	localparam int MAX_ENTRIES_DEF = 16;
	localparam int WEIGHT_BITS_DEF = 16;

	// fixed field widths
	localparam int ENTRY_IDX_W = 4;
	localparam int WEIGHT_W    = 16;
	localparam int TOTAL_W     = 20;
	localparam int EIU_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_DUP      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_OVR      = 2'd2;

	// configuration reset values
	localparam logic [EIU_W-1:0]   EIU_RST = 5'd1;
	localparam logic               DUP_RST = 1'b1;
	localparam logic [TOTAL_W-1:0] OVR_RST = '0;

	// request codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_DRAW = 1'b1;

	typedef struct packed {
		logic capture;  // latch the accepted request
		logic write;    // write the load weight, clear removal marks
		logic rd_en;    // read one table entry
		logic proc;     // process the entry in the read stage
		logic emit;     // load the result register
	} ctl_cmd_t;

	typedef struct packed {
		logic override_nz;  // total override register is nonzero
		logic hit;          // draw entry in the read stage is a hit
		logic data_vld;     // read stage holds an entry
	} ctl_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/weighted_index_select_unit.sv -----
// top level of the weighted index select unit (roulette-wheel selection)
// depends on wis_pkg, wis_ctrl, wis_dpath
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------------
//   req     | req_valid, req_stall  | req_type, entry_index, weight, random_value
//   rsp     | rsp_valid, rsp_stall  | found, chosen_index, remaining_total
//   cfg     | cfg_valid, cfg_ready  | cfg_index, cfg_data
//
// one request at a time; the weight memory is scanned one entry per cycle through
// its single registered read port, over min(entries_in_use, MAX_ENTRIES) entries
// a load writes its weight, sums the table unless the override is nonzero, then emits
// a draw scans the table and stops early on the hit entry
// reset clears state, removal marks and per-entry valid bits and sets config to its
// reset values; unwritten entries read as zero weight, so no clearing pass is needed
// the result register lets the next request be taken while a result waits on rsp_stall
`default_nettype none

module weighted_index_select_unit #(
	parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request channel
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic                                req_type,
	input  wire logic [wis_pkg::ENTRY_IDX_W-1:0]     entry_index,
	input  wire logic [wis_pkg::WEIGHT_W-1:0]        weight,
	input  wire logic [wis_pkg::TOTAL_W-1:0]         random_value,
	// result channel
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic                                     found,
	output logic [wis_pkg::ENTRY_IDX_W-1:0]          chosen_index,
	output logic [wis_pkg::TOTAL_W-1:0]              remaining_total,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [wis_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	wis_pkg::ctl_cmd_t cmd;
	wis_pkg::ctl_sts_t sts;
	logic [CW-1:0]     active_cnt;
	logic [AW-1:0]     rd_addr;
	logic              cfg_we;

	// config writes are always taken; the sender must issue them only while the unit is idle; the unit does not check
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// state machine: idle, weight write, table scan, result hand-off
	wis_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_type   (req_type),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.active_cnt (active_cnt),
		.cmd        (cmd),
		.rd_addr    (rd_addr)
	);

	// weight memory, marks, accumulator, running total and result register
	wis_dpath #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.active_cnt      (active_cnt),
		.rd_addr         (rd_addr),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.entry_index     (entry_index),
		.weight          (weight),
		.random_value    (random_value),
		.found           (found),
		.chosen_index    (chosen_index),
		.remaining_total (remaining_total)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/wis_ctrl.sv -----
// controller state machine for the weighted index select unit
// depends on wis_pkg
`default_nettype none

module wis_ctrl #(
	parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_type,
	output logic                   req_stall,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	input  wire wis_pkg::ctl_sts_t sts,
	input  wire logic [CW-1:0]     active_cnt,
	output wis_pkg::ctl_cmd_t      cmd,
	output logic [AW-1:0]          rd_addr
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q, state_n;
	logic [CW-1:0] issue_q, issue_n;
	logic          rsp_valid_q;

	assign rd_addr   = issue_q[AW-1:0];
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		issue_n = issue_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					issue_n     = '0;
					state_n     = (req_type == wis_pkg::REQ_LOAD) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
				state_n   = sts.override_nz ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.proc = 1'b1;
				priority if (sts.hit && sts.data_vld) begin
					state_n = ST_DONE;
				end else if (issue_q != active_cnt) begin
					cmd.rd_en = 1'b1;
					issue_n   = issue_q + 1'b1;
				end else if (!sts.data_vld) begin
					state_n = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			issue_q <= issue_n;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/wis_dpath.sv -----
// datapath for the weighted index select unit: config registers, weight memory,
// removal marks, scan accumulator, running total and result register
// depends on wis_pkg
`default_nettype none

module wis_dpath #(
	parameter int MAX_ENTRIES = wis_pkg::MAX_ENTRIES_DEF,
	parameter int WEIGHT_BITS = wis_pkg::WEIGHT_BITS_DEF,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
	localparam int CW = $clog2(MAX_ENTRIES + 1),
	localparam int WB = (WEIGHT_BITS < wis_pkg::WEIGHT_W) ? WEIGHT_BITS : wis_pkg::WEIGHT_W
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire wis_pkg::ctl_cmd_t                   cmd,
	output wis_pkg::ctl_sts_t                        sts,
	output logic [CW-1:0]                            active_cnt,
	input  wire logic [AW-1:0]                       rd_addr,
	input  wire logic                                cfg_we,
	input  wire logic [wis_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [wis_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                req_type,
	input  wire logic [wis_pkg::ENTRY_IDX_W-1:0]     entry_index,
	input  wire logic [wis_pkg::WEIGHT_W-1:0]        weight,
	input  wire logic [wis_pkg::TOTAL_W-1:0]         random_value,
	output logic                                     found,
	output logic [wis_pkg::ENTRY_IDX_W-1:0]          chosen_index,
	output logic [wis_pkg::TOTAL_W-1:0]              remaining_total
);

	localparam int TW = wis_pkg::TOTAL_W;
	localparam int IW = wis_pkg::ENTRY_IDX_W;

	// configuration
	logic [wis_pkg::EIU_W-1:0] cfg_eiu_q;
	logic                      cfg_dup_q;
	logic [TW-1:0]             cfg_ovr_q;

	// captured request
	logic          op_load_q;
	logic [IW-1:0] widx_q;
	logic [WB-1:0] wval_q;

	// scan state
	logic [TW-1:0]          acc_q;
	logic [TW-1:0]          total_q;
	logic                   found_q;
	logic [IW-1:0]          chosen_q;
	logic [MAX_ENTRIES-1:0] rem_q;
	logic [MAX_ENTRIES-1:0] ent_vld_q;

	// weight memory and read stage
	logic [WB-1:0] mem [MAX_ENTRIES];
	logic [WB-1:0] rd_data_s1;
	logic          ent_vld_s1;
	logic          data_vld_s1;
	logic [AW-1:0] idx_s1;

	// result register
	logic          rsp_found_q;
	logic [IW-1:0] rsp_index_q;
	logic [TW-1:0] rsp_total_q;

	logic [AW+IW-1:0] wr_addr_ext;
	logic [AW-1:0]    wr_addr;
	logic             wr_in_range;
	logic [AW+IW-1:0] chosen_ext;
	logic [TW-1:0]    w_eff;
	logic [TW:0]      sum_wide;
	logic             entry_rem;
	logic             raw_hit;
	logic             do_proc;
	logic [TW-1:0]    new_total;

	always_comb begin
		if (32'(cfg_eiu_q) > MAX_ENTRIES) begin
			active_cnt = CW'(MAX_ENTRIES);
		end else begin
			active_cnt = CW'(cfg_eiu_q);
		end
	end

	assign wr_addr_ext = (AW + IW)'(widx_q);
	assign wr_addr     = wr_addr_ext[AW-1:0];
	assign wr_in_range = (32'(widx_q) < MAX_ENTRIES);
	assign chosen_ext  = (AW + IW)'(idx_s1);

	assign w_eff     = ent_vld_s1 ? TW'(rd_data_s1) : '0;
	assign sum_wide  = {1'b0, acc_q} + {1'b0, w_eff};
	assign entry_rem = rem_q[idx_s1];
	assign raw_hit   = !op_load_q && !entry_rem && (acc_q < w_eff);
	assign do_proc   = cmd.proc && data_vld_s1;
	assign new_total = op_load_q ? ((cfg_ovr_q != '0) ? cfg_ovr_q : acc_q) : total_q;

	assign sts.override_nz = (cfg_ovr_q != '0);
	assign sts.hit         = raw_hit;
	assign sts.data_vld    = data_vld_s1;

	assign found           = rsp_found_q;
	assign chosen_index    = rsp_index_q;
	assign remaining_total = rsp_total_q;

	// config registers and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_eiu_q   <= wis_pkg::EIU_RST;
			cfg_dup_q   <= wis_pkg::DUP_RST;
			cfg_ovr_q   <= wis_pkg::OVR_RST;
			total_q     <= '0;
			rem_q       <= '0;
			ent_vld_q   <= '0;
			data_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wis_pkg::REG_ENTRIES_IN_USE: cfg_eiu_q <= cfg_data[wis_pkg::EIU_W-1:0];
					wis_pkg::REG_ALLOW_DUP:      cfg_dup_q <= cfg_data[0];
					wis_pkg::REG_TOTAL_OVR:      cfg_ovr_q <= cfg_data[TW-1:0];
					default: begin
					end
				endcase
			end
			data_vld_s1 <= cmd.rd_en;
			if (cmd.write) begin
				rem_q <= '0;
				if (wr_in_range) begin
					ent_vld_q[wr_addr] <= 1'b1;
				end
			end
			if (do_proc && raw_hit && !cfg_dup_q) begin
				rem_q[idx_s1] <= 1'b1;
				total_q       <= (w_eff >= total_q) ? '0 : total_q - w_eff;
			end
			if (cmd.emit) begin
				total_q <= new_total;
			end
		end
	end

	// weight memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write && wr_in_range) begin
			mem[wr_addr] <= wval_q;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		ent_vld_s1 <= ent_vld_q[rd_addr];
		idx_s1     <= rd_addr;
		if (cmd.capture) begin
			op_load_q <= (req_type == wis_pkg::REQ_LOAD);
			widx_q    <= entry_index;
			wval_q    <= weight[WB-1:0];
			acc_q     <= (req_type == wis_pkg::REQ_LOAD) ? '0 : random_value;
			found_q   <= 1'b0;
			chosen_q  <= '0;
		end else if (do_proc) begin
			if (op_load_q) begin
				// saturating weight sum
				acc_q <= sum_wide[TW] ? wis_pkg::TOTAL_MAX : sum_wide[TW-1:0];
			end else if (raw_hit) begin
				found_q  <= 1'b1;
				chosen_q <= chosen_ext[IW-1:0];
			end else if (!entry_rem) begin
				acc_q <= acc_q - w_eff;
			end
		end
		if (cmd.emit) begin
			rsp_found_q <= found_q;
			rsp_index_q <= chosen_q;
			rsp_total_q <= new_total;
		end
	end

endmodule

`default_nettype wire

// ----- verif/weighted_index_select_unit_test.sv -----
// self-checking testbench for weighted_index_select_unit: loads and draws with a
// scoreboard class that predicts each selection, random idling on both channels
// depends on wis_pkg and the weighted_index_select_unit rtl
module weighted_index_select_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH    = wis_pkg::MAX_ENTRIES_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 32;
	localparam int SEGMENTS       = 6;
	localparam int SEGMENT_ITEMS  = 130;

	// register index with no register behind it, writes are ignored
	localparam logic [wis_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// one result transaction
	typedef struct packed {
		logic                            found;
		logic [wis_pkg::ENTRY_IDX_W-1:0] chosen_index;
		logic [wis_pkg::TOTAL_W-1:0]     remaining_total;
	} selection_t;

	// weight table mirror plus the queue of selections still to come
	class selection_scoreboard;
		logic [wis_pkg::WEIGHT_W-1:0] weights [TABLE_DEPTH];
		logic [TABLE_DEPTH-1:0]       removed;
		logic [wis_pkg::TOTAL_W-1:0]  running_total;
		logic [wis_pkg::EIU_W-1:0]    entries_in_use;
		logic                         allow_dup;
		logic [wis_pkg::TOTAL_W-1:0]  total_ovr;
		selection_t                   pending_results [$];
		int                           errors;

		function new();
			foreach (weights[i]) weights[i] = '0;
			removed        = '0;
			running_total  = '0;
			entries_in_use = wis_pkg::EIU_RST;
			allow_dup      = wis_pkg::DUP_RST;
			total_ovr      = wis_pkg::OVR_RST;
			errors         = 0;
		endfunction

		function int active_entries();
			return (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(entries_in_use);
		endfunction

		function void write_register(logic [wis_pkg::CFG_IDX_W-1:0] idx,
				logic [wis_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				wis_pkg::REG_ENTRIES_IN_USE: entries_in_use = data[wis_pkg::EIU_W-1:0];
				wis_pkg::REG_ALLOW_DUP:      allow_dup      = data[0];
				wis_pkg::REG_TOTAL_OVR:      total_ovr      = data[wis_pkg::TOTAL_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_request(logic rt, logic [wis_pkg::ENTRY_IDX_W-1:0] idx,
				logic [wis_pkg::WEIGHT_W-1:0] w, logic [wis_pkg::TOTAL_W-1:0] rv);
			selection_t                  res;
			logic [wis_pkg::TOTAL_W:0]   sum;
			logic [wis_pkg::TOTAL_W-1:0] left;
			int                          n;
			n   = active_entries();
			res = '0;
			if (rt == wis_pkg::REQ_LOAD) begin
				weights[idx] = w;
				removed      = '0;
				if (total_ovr != '0) begin
					running_total = total_ovr;
				end else begin
					sum = '0;
					for (int i = 0; i < n; i++) sum += (wis_pkg::TOTAL_W + 1)'(weights[i]);
					running_total = (sum > (wis_pkg::TOTAL_W + 1)'(wis_pkg::TOTAL_MAX))
						? wis_pkg::TOTAL_MAX : sum[wis_pkg::TOTAL_W-1:0];
				end
			end else begin
				left = rv;
				for (int i = 0; i < n && !res.found; i++) begin
					if (!removed[i]) begin
						if (left < wis_pkg::TOTAL_W'(weights[i])) begin
							res.found        = 1'b1;
							res.chosen_index = wis_pkg::ENTRY_IDX_W'(i);
							if (!allow_dup) begin
								removed[i]    = 1'b1;
								running_total =
									(wis_pkg::TOTAL_W'(weights[i]) >= running_total) ? '0
									: running_total - wis_pkg::TOTAL_W'(weights[i]);
							end
						end else begin
							left -= wis_pkg::TOTAL_W'(weights[i]);
						end
					end
				end
			end
			res.remaining_total = running_total;
			pending_results.push_back(res);
		endfunction

		function void check_result(logic f, logic [wis_pkg::ENTRY_IDX_W-1:0] ci,
				logic [wis_pkg::TOTAL_W-1:0] rt);
			selection_t want;
			if (pending_results.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (f !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, f);
					errors++;
				end
				if (ci !== want.chosen_index) begin
					$error("chosen_index: expected %0d, actual %0d", want.chosen_index, ci);
					errors++;
				end
				if (rt !== want.remaining_total) begin
					$error("remaining_total: expected %0d, actual %0d", want.remaining_total, rt);
					errors++;
				end
			end
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic                            clk;
	logic                            arst_n       = 1'b0;
	logic                            req_valid    = 1'b0;
	logic                            req_type     = wis_pkg::REQ_LOAD;
	logic [wis_pkg::ENTRY_IDX_W-1:0] entry_index  = '0;
	logic [wis_pkg::WEIGHT_W-1:0]    weight       = '0;
	logic [wis_pkg::TOTAL_W-1:0]     random_value = '0;
	logic                            rsp_stall    = 1'b0;
	logic                            cfg_valid    = 1'b0;
	logic [wis_pkg::CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [wis_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	logic                            req_stall;
	logic                            rsp_valid;
	logic                            found;
	logic [wis_pkg::ENTRY_IDX_W-1:0] chosen_index;
	logic [wis_pkg::TOTAL_W-1:0]     remaining_total;
	logic                            cfg_ready;

	selection_scoreboard sb;

	// idle rates in percent, changed only while the block is drained
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// hold-off request: main flips the trigger, the receiver counts the stretch itself
	bit hold_trigger = 1'b0;
	bit hold_seen    = 1'b0;
	int hold_left    = 0;
	int quiet_cycles = 0;

	weighted_index_select_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.entry_index     (entry_index),
		.weight          (weight),
		.random_value    (random_value),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.found           (found),
		.chosen_index    (chosen_index),
		.remaining_total (remaining_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: check each accepted result, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				sb.check_result(found, chosen_index, remaining_total);
			if (hold_trigger != hold_seen) begin
				hold_seen = hold_trigger;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// long hold-off so the block backs up and stalls its request side
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// watchdog: any cycle without a transaction on any channel counts as quiet
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("weighted_index_select_unit_test: FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// offer one request, with random idle cycles ahead of it, and record it once taken
	task automatic send_request(logic rt, logic [wis_pkg::ENTRY_IDX_W-1:0] idx,
			logic [wis_pkg::WEIGHT_W-1:0] w, logic [wis_pkg::TOTAL_W-1:0] rv);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		req_type     <= rt;
		entry_index  <= idx;
		weight       <= w;
		random_value <= rv;
		do @(posedge clk); while (req_stall);
		sb.note_request(rt, idx, w, rv);
	endtask

	// sender pause: every expected result has to come back before going on
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one register write transaction, only called with the block drained
	task automatic write_register(logic [wis_pkg::CFG_IDX_W-1:0] idx,
			logic [wis_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_random();
		logic [wis_pkg::CFG_DATA_W-1:0] eiu;
		logic [wis_pkg::CFG_DATA_W-1:0] ovr;
		case ($urandom_range(0, 7))
			0:       eiu = wis_pkg::CFG_DATA_W'(1);
			1, 2, 3: eiu = wis_pkg::CFG_DATA_W'(TABLE_DEPTH);
			4:       eiu = wis_pkg::CFG_DATA_W'($urandom_range(0, 31));
			default: eiu = wis_pkg::CFG_DATA_W'($urandom_range(2, TABLE_DEPTH));
		endcase
		case ($urandom_range(0, 7))
			0:       ovr = wis_pkg::TOTAL_MAX;
			1:       ovr = wis_pkg::CFG_DATA_W'($urandom_range(1, 20'hFFFFF));
			2:       ovr = wis_pkg::CFG_DATA_W'($urandom_range(1, 2000));
			default: ovr = '0;
		endcase
		write_register(wis_pkg::REG_ENTRIES_IN_USE, eiu);
		write_register(wis_pkg::REG_ALLOW_DUP, wis_pkg::CFG_DATA_W'($urandom_range(0, 1)));
		write_register(wis_pkg::REG_TOTAL_OVR, ovr);
	endtask

	// mostly draws aimed below the running total, loads keep refilling the table
	task automatic send_random_request();
		logic                            rt;
		logic [wis_pkg::ENTRY_IDX_W-1:0] idx;
		logic [wis_pkg::WEIGHT_W-1:0]    w;
		logic [wis_pkg::TOTAL_W-1:0]     rv;
		int                              n;
		n   = sb.active_entries();
		idx = wis_pkg::ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
		w   = wis_pkg::WEIGHT_W'($urandom_range(0, 16'hFFFF));
		rv  = wis_pkg::TOTAL_W'($urandom_range(0, 20'hFFFFF));
		if ($urandom_range(0, 99) < 30) begin
			rt = wis_pkg::REQ_LOAD;
			if (n > 0 && $urandom_range(0, 3) != 0)
				idx = wis_pkg::ENTRY_IDX_W'($urandom_range(0, n - 1));
			case ($urandom_range(0, 7))
				0:       w = '0;
				1:       w = '1;
				2, 3:    w = wis_pkg::WEIGHT_W'($urandom_range(0, 255));
				default: ;
			endcase
		end else begin
			rt = wis_pkg::REQ_DRAW;
			if (sb.running_total != '0 && $urandom_range(0, 99) < 88)
				rv = wis_pkg::TOTAL_W'($urandom_range(0, int'(sb.running_total) - 1));
		end
		send_request(rt, idx, w, rv);
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table straight after reset, draw misses
		send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		wait_for_results();

		// full table width, heaviest weights at both ends, a weight of one at entry 5 between
		write_register(wis_pkg::REG_ENTRIES_IN_USE, wis_pkg::CFG_DATA_W'(TABLE_DEPTH));
		write_register(REG_UNUSED, '1);
		send_request(wis_pkg::REQ_LOAD, 4'd0, '1, '0);
		send_request(wis_pkg::REQ_LOAD, '1, '1, '1);
		send_request(wis_pkg::REQ_LOAD, 4'd5, 16'd1, '0);
		send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		send_request(wis_pkg::REQ_DRAW, '1, '1, 20'd65535);
		send_request(wis_pkg::REQ_DRAW, '0, '0, 20'd65536);
		// value at or above the total scans through and misses
		send_request(wis_pkg::REQ_DRAW, '0, '0, wis_pkg::TOTAL_MAX);
		wait_for_results();

		// removing draws until the table is used up, then a load brings it back
		write_register(wis_pkg::REG_ALLOW_DUP, '0);
		repeat (4) send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		send_request(wis_pkg::REQ_LOAD, 4'd5, 16'd1, '0);
		wait_for_results();

		// override write leaves the total alone until the next load
		write_register(wis_pkg::REG_TOTAL_OVR, 20'd100);
		send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		send_request(wis_pkg::REQ_LOAD, 4'd3, 16'h8000, '0);
		// removal of a weight above the running total clamps it to zero
		send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		wait_for_results();

		write_register(wis_pkg::REG_TOTAL_OVR, wis_pkg::TOTAL_MAX);
		send_request(wis_pkg::REQ_LOAD, 4'd7, 16'h00FF, '0);
		send_request(wis_pkg::REQ_DRAW, '0, '0, 20'hFFFFE);
		wait_for_results();

		// no entries in use, then a count above the table that saturates
		write_register(wis_pkg::REG_ENTRIES_IN_USE, '0);
		write_register(wis_pkg::REG_TOTAL_OVR, '0);
		send_request(wis_pkg::REQ_LOAD, 4'd1, 16'h1234, '0);
		send_request(wis_pkg::REQ_DRAW, '0, '0, '0);
		wait_for_results();
		write_register(wis_pkg::REG_ENTRIES_IN_USE, wis_pkg::CFG_DATA_W'(31));
		send_request(wis_pkg::REQ_LOAD, 4'd2, 16'h0010, '0);
		send_request(wis_pkg::REQ_DRAW, '0, '0, 20'd131080);

		// random segments: slow receiver, then slow sender, then full rate
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			wait_for_results();
			case (seg / 2)
				0: begin
					send_idle_pct = 8;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 8;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			configure_random();
			for (int k = 0; k < SEGMENT_ITEMS; k++) begin
				if (seg == SEGMENTS - 2 && k == 10)
					hold_trigger = ~hold_trigger;
				if (k == SEGMENT_ITEMS / 2)
					wait_for_results();
				send_random_request();
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("weighted_index_select_unit_test: PASS");
		end else begin
			if (sb.pending_results.size() != 0)
				$error("%0d expected results never arrived", sb.pending_results.size());
			$display("weighted_index_select_unit_test: FAIL");
		end
		$finish;
	end

endmodule
